>>> rtl/rrds_pkg.sv
// ============================================================================
// rrds_pkg
// Shared types, constants and direction tables of the radial ray distance
// stamp: map geometry, item kinds, register indexes and the sine quarter table.
// ============================================================================
package rrds_pkg;

    localparam int MAX_DIM        = 64;
    localparam int RAY_COUNT      = 100;
    localparam int QUARTER_RAYS   = RAY_COUNT / 4;
    localparam int MAX_RADIUS_DEF = 30;

    localparam int POS_W     = 6;
    localparam int DIST_W    = 6;
    localparam int KIND_W    = 2;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int MAP_CELLS = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(MAP_CELLS);
    localparam int FRAC_W    = 16;
    localparam int TRIG_W    = FRAC_W + 2;
    localparam int RAYJ_W    = $clog2(QUARTER_RAYS + 1);

    localparam logic [DIST_W-1:0] DIST_FAR   = '1;
    localparam logic [CFG_W-1:0]  GRID_RESET = CFG_W'(MAX_DIM);

    localparam logic [KIND_W-1:0] KIND_WALL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STAMP = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH = 1'd1;

    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
        logic                  wr_wall_en;
        logic                  wr_dist_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic                  wall_data;
        logic [DIST_W-1:0]     dist_data;
    } map_req_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } trig_t;

    // round(sin(j * pi / 50) * 65536)
    function automatic logic [FRAC_W:0] quarter_sin(input logic [RAYJ_W-1:0] j);
        logic [FRAC_W:0] v;
        unique case (j)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd4115;
            5'd2:    v = 17'd8214;
            5'd3:    v = 17'd12280;
            5'd4:    v = 17'd16298;
            5'd5:    v = 17'd20252;
            5'd6:    v = 17'd24125;
            5'd7:    v = 17'd27904;
            5'd8:    v = 17'd31572;
            5'd9:    v = 17'd35116;
            5'd10:   v = 17'd38521;
            5'd11:   v = 17'd41774;
            5'd12:   v = 17'd44862;
            5'd13:   v = 17'd47774;
            5'd14:   v = 17'd50496;
            5'd15:   v = 17'd53020;
            5'd16:   v = 17'd55334;
            5'd17:   v = 17'd57430;
            5'd18:   v = 17'd59299;
            5'd19:   v = 17'd60934;
            5'd20:   v = 17'd62328;
            5'd21:   v = 17'd63477;
            5'd22:   v = 17'd64375;
            5'd23:   v = 17'd65019;
            5'd24:   v = 17'd65407;
            5'd25:   v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // direction of ray quad * QUARTER_RAYS + j
    function automatic trig_t ray_dir(input logic [1:0] quad, input logic [RAYJ_W-1:0] j);
        logic signed [TRIG_W-1:0] sq;
        logic signed [TRIG_W-1:0] cq;
        trig_t d;
        sq = signed'({1'b0, quarter_sin(j)});
        cq = signed'({1'b0, quarter_sin(RAYJ_W'(QUARTER_RAYS) - j)});
        unique case (quad)
            2'd0:
            begin
                d.cos_v = cq;
                d.sin_v = sq;
            end
            2'd1:
            begin
                d.cos_v = -sq;
                d.sin_v = cq;
            end
            2'd2:
            begin
                d.cos_v = -cq;
                d.sin_v = -sq;
            end
            2'd3:
            begin
                d.cos_v = sq;
                d.sin_v = -cq;
            end
        endcase
        return d;
    endfunction

endpackage

>>> rtl/rrds_maps.sv
// ============================================================================
// rrds_maps
// Wall and distance map memories with one read and one write port each,
// same-entry forwarding and the clearing sweep that runs after reset.
// ============================================================================
module rrds_maps
    import rrds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  map_req_t          req,
    output logic              wall_q,
    output logic [DIST_W-1:0] dist_q,
    output logic              clear_busy
);

    logic              wall_mem [MAP_CELLS];
    logic [DIST_W-1:0] dist_mem [MAP_CELLS];

    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              fwd_wall_hit_reg;
    logic              fwd_wall_hit_next;
    logic              fwd_dist_hit_reg;
    logic              fwd_dist_hit_next;
    logic              fwd_wall_reg;
    logic [DIST_W-1:0] fwd_dist_reg;
    logic              wall_rd_reg;
    logic [DIST_W-1:0] dist_rd_reg;

    logic              wr_wall_en;
    logic              wr_dist_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_wall_data;
    logic [DIST_W-1:0] wr_dist_data;

    always_comb
    begin
        wr_wall_en    = clr_busy_reg || req.wr_wall_en;
        wr_dist_en    = clr_busy_reg || req.wr_dist_en;
        wr_addr       = clr_busy_reg ? clr_addr_reg : req.wr_addr;
        wr_wall_data  = clr_busy_reg ? 1'b0 : req.wall_data;
        wr_dist_data  = clr_busy_reg ? DIST_FAR : req.dist_data;

        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(MAP_CELLS - 1))
                clr_busy_next = 1'b0;
            else
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
        end

        fwd_wall_hit_next = fwd_wall_hit_reg;
        fwd_dist_hit_next = fwd_dist_hit_reg;
        if (req.rd_en)
        begin
            fwd_wall_hit_next = wr_wall_en && (wr_addr == req.rd_addr);
            fwd_dist_hit_next = wr_dist_en && (wr_addr == req.rd_addr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg     <= 1'b1;
            clr_addr_reg     <= '0;
            fwd_wall_hit_reg <= 1'b0;
            fwd_dist_hit_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg     <= clr_busy_next;
            clr_addr_reg     <= clr_addr_next;
            fwd_wall_hit_reg <= fwd_wall_hit_next;
            fwd_dist_hit_reg <= fwd_dist_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_wall_en)
            wall_mem[wr_addr] <= wr_wall_data;
        if (wr_dist_en)
            dist_mem[wr_addr] <= wr_dist_data;
        if (req.rd_en)
        begin
            wall_rd_reg  <= wall_mem[req.rd_addr];
            dist_rd_reg  <= dist_mem[req.rd_addr];
            fwd_wall_reg <= wr_wall_data;
            fwd_dist_reg <= wr_dist_data;
        end
    end

    assign wall_q     = fwd_wall_hit_reg ? fwd_wall_reg : wall_rd_reg;
    assign dist_q     = fwd_dist_hit_reg ? fwd_dist_reg : dist_rd_reg;
    assign clear_busy = clr_busy_reg;

endmodule

>>> rtl/radial_ray_distance_stamp.sv
// ============================================================================
// radial_ray_distance_stamp
// Wall and distance maps over a grid with cell writes, cell reads and radial
// distance stamps from a point.
// ============================================================================
// usage
//   input channel (in_valid / in_stall) takes one transaction per item:
//   kind, x_pos, y_pos, value. output channel (out_valid / out_stall) gives
//   one transaction per item: read_distance, the stored distance for a read,
//   else zero. grid_width / grid_depth are written on cfg_wr_en; the user
//   writes them only while idle, which the block itself does not enforce.
//   a wall or distance write goes straight to the result state, a read
//   first through the read state. a stamp walks 100 rays: it loads each ray,
//   does one map read per step and retires the last step.
//   one item is worked on at a time; the next is taken once the previous
//   result sits in the output register, even while the receiver stalls it.
//   a stalled result holds; a finished item waits for the output register.
//   after reset both maps are swept, one cell per cycle, with in_stall
//   high; configuration writes are taken during the sweep.
// ============================================================================
module radial_ray_distance_stamp
    import rrds_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [KIND_W-1:0]    kind,
    input  logic [POS_W-1:0]     x_pos,
    input  logic [POS_W-1:0]     y_pos,
    input  logic [DIST_W-1:0]    value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DIST_W-1:0]    read_distance,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int RAD_W = $clog2(MAX_RADIUS + 1);
    localparam int ACC_W = POS_W + RAD_W + FRAC_W + 2;
    localparam int INT_W = ACC_W - FRAC_W - 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_STAMP  = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] c;
    } axis_t;

    function automatic logic [ADDR_W-1:0] cell_index(
        input logic [POS_W-1:0] cx,
        input logic [POS_W-1:0] cy,
        input logic [DIM_W-1:0] w
    );
        logic [POS_W+DIM_W-1:0] prod;
        prod = {{DIM_W{1'b0}}, cy} * {{POS_W{1'b0}}, w};
        return prod[ADDR_W-1:0] + {{(ADDR_W-POS_W){1'b0}}, cx};
    endfunction

    // truncate toward zero and check against the grid limit
    function automatic axis_t axis_cell(
        input logic signed [ACC_W-1:0] a,
        input logic [DIM_W-1:0]        lim
    );
        logic [INT_W-1:0] ip;
        logic             above;
        axis_t            res;
        ip     = a[ACC_W-1] ? '0 : a[ACC_W-2:FRAC_W];
        above  = !a[ACC_W-1] || ((&a[ACC_W-1:FRAC_W]) && (|a[FRAC_W-1:0]));
        res.ok = above && (ip < {{(INT_W-DIM_W){1'b0}}, lim});
        res.c  = ip[POS_W-1:0];
        return res;
    endfunction

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [CFG_W-1:0]        gw_reg;
    logic [CFG_W-1:0]        gd_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [DIST_W-1:0]       out_data_reg;
    logic [DIST_W-1:0]       out_data_next;
    logic [DIST_W-1:0]       res_reg;
    logic [DIST_W-1:0]       res_next;
    logic                    rd_in_reg;
    logic                    rd_in_next;
    logic [POS_W-1:0]        org_x_reg;
    logic [POS_W-1:0]        org_x_next;
    logic [POS_W-1:0]        org_y_reg;
    logic [POS_W-1:0]        org_y_next;
    logic [1:0]              quad_reg;
    logic [1:0]              quad_next;
    logic [RAYJ_W-1:0]       ray_j_reg;
    logic [RAYJ_W-1:0]       ray_j_next;
    logic signed [ACC_W-1:0] acc_x_reg;
    logic signed [ACC_W-1:0] acc_x_next;
    logic signed [ACC_W-1:0] acc_y_reg;
    logic signed [ACC_W-1:0] acc_y_next;
    logic [RAD_W-1:0]        r1_reg;
    logic [RAD_W-1:0]        r1_next;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s2_valid_reg;
    logic                    s2_valid_next;
    logic                    s2_in_reg;
    logic                    s2_in_next;
    logic [ADDR_W-1:0]       s2_idx_reg;
    logic [ADDR_W-1:0]       s2_idx_next;
    logic [RAD_W-1:0]        s2_r_reg;
    logic [RAD_W-1:0]        s2_r_next;
    logic                    s2_last_reg;
    logic                    s2_last_next;

    logic [DIM_W-1:0]        w_eff;
    logic [DIM_W-1:0]        d_eff;
    map_req_t                req;
    logic                    wall_q;
    logic [DIST_W-1:0]       dist_q;
    logic                    clear_busy;
    trig_t                   dir;
    logic signed [TRIG_W-1:0] dir_cos;
    logic signed [TRIG_W-1:0] dir_sin;
    logic signed [ACC_W-1:0] origin_x;
    logic signed [ACC_W-1:0] origin_y;
    axis_t                   ax;
    axis_t                   ay;
    logic [ADDR_W-1:0]       ray_addr;
    logic [ADDR_W-1:0]       port_addr;
    logic                    port_in;
    logic                    in_take;
    logic                    stop;
    logic                    ray_end;
    logic                    lower;
    logic                    last_ray;

    assign w_eff = (gw_reg > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(gw_reg);
    assign d_eff = (gd_reg > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(gd_reg);

    assign in_stall      = (state_reg != ST_IDLE) || clear_busy;
    assign in_take       = in_valid && !in_stall;
    assign out_valid     = out_valid_reg;
    assign read_distance = out_data_reg;

    rrds_maps u_maps (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .wall_q     (wall_q),
        .dist_q     (dist_q),
        .clear_busy (clear_busy)
    );

    always_comb
    begin
        dir      = ray_dir(quad_reg, ray_j_reg);
        dir_cos  = dir.cos_v;
        dir_sin  = dir.sin_v;
        origin_x = $signed({{(ACC_W-POS_W-FRAC_W){1'b0}}, org_x_reg, {FRAC_W{1'b0}}});
        origin_y = $signed({{(ACC_W-POS_W-FRAC_W){1'b0}}, org_y_reg, {FRAC_W{1'b0}}});
        ax        = axis_cell(acc_x_reg, w_eff);
        ay        = axis_cell(acc_y_reg, d_eff);
        ray_addr  = cell_index(ax.c, ay.c, w_eff);
        port_in   = (DIM_W'(x_pos) < w_eff) && (DIM_W'(y_pos) < d_eff);
        port_addr = cell_index(x_pos, y_pos, w_eff);

        stop     = !s2_in_reg || wall_q;
        ray_end  = (state_reg == ST_STAMP) && s2_valid_reg && (stop || s2_last_reg);
        lower    = (state_reg == ST_STAMP) && s2_valid_reg && !stop
                   && (dist_q > DIST_W'(s2_r_reg));
        last_ray = (quad_reg == 2'd3) && (ray_j_reg == RAYJ_W'(QUARTER_RAYS - 1));

        state_next    = state_reg;
        res_next      = res_reg;
        rd_in_next    = rd_in_reg;
        org_x_next    = org_x_reg;
        org_y_next    = org_y_reg;
        quad_next     = quad_reg;
        ray_j_next    = ray_j_reg;
        acc_x_next    = acc_x_reg;
        acc_y_next    = acc_y_reg;
        r1_next       = r1_reg;
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        s2_in_next    = s2_in_reg;
        s2_idx_next   = s2_idx_reg;
        s2_r_next     = s2_r_reg;
        s2_last_next  = s2_last_reg;

        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        req            = '0;
        req.rd_addr    = port_addr;
        req.wr_addr    = port_addr;
        req.wall_data  = value[0];
        req.dist_data  = value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    res_next = '0;
                    unique case (kind)
                        KIND_WALL:
                        begin
                            req.wr_wall_en = port_in;
                            state_next     = ST_RESULT;
                        end
                        KIND_DIST:
                        begin
                            req.wr_dist_en = port_in;
                            state_next     = ST_RESULT;
                        end
                        KIND_STAMP:
                        begin
                            org_x_next    = x_pos;
                            org_y_next    = y_pos;
                            quad_next     = 2'd0;
                            ray_j_next    = '0;
                            s1_valid_next = 1'b0;
                            s2_valid_next = 1'b0;
                            state_next    = ST_STAMP;
                        end
                        KIND_READ:
                        begin
                            req.rd_en  = 1'b1;
                            rd_in_next = port_in;
                            state_next = ST_READ;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_next   = rd_in_reg ? dist_q : '0;
                state_next = ST_RESULT;
            end
            ST_STAMP:
            begin
                req.rd_en      = s1_valid_reg && !ray_end;
                req.rd_addr    = ray_addr;
                req.wr_dist_en = lower;
                req.wr_addr    = s2_idx_reg;
                req.dist_data  = DIST_W'(s2_r_reg);
                if (ray_end)
                begin
                    s1_valid_next = 1'b0;
                    s2_valid_next = 1'b0;
                    if (last_ray)
                        state_next = ST_RESULT;
                    else if (ray_j_reg == RAYJ_W'(QUARTER_RAYS - 1))
                    begin
                        ray_j_next = '0;
                        quad_next  = quad_reg + 2'd1;
                    end
                    else
                        ray_j_next = ray_j_reg + RAYJ_W'(1);
                end
                else if (s1_valid_reg)
                begin
                    s2_valid_next = 1'b1;
                    s2_in_next    = ax.ok && ay.ok;
                    s2_idx_next   = ray_addr;
                    s2_r_next     = r1_reg;
                    s2_last_next  = (r1_reg == RAD_W'(MAX_RADIUS));
                    acc_x_next    = acc_x_reg + ACC_W'(dir_cos);
                    acc_y_next    = acc_y_reg + ACC_W'(dir_sin);
                    r1_next       = r1_reg + RAD_W'(1);
                    s1_valid_next = (r1_reg != RAD_W'(MAX_RADIUS));
                end
                else if (!s2_valid_reg)
                begin
                    // first step of a new ray
                    acc_x_next    = origin_x + ACC_W'(dir_cos);
                    acc_y_next    = origin_y + ACC_W'(dir_sin);
                    r1_next       = RAD_W'(1);
                    s1_valid_next = 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            gw_reg        <= GRID_RESET;
            gd_reg        <= GRID_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_GRID_WIDTH: gw_reg <= cfg_data;
                    CFG_GRID_DEPTH: gd_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        res_reg      <= res_next;
        rd_in_reg    <= rd_in_next;
        org_x_reg    <= org_x_next;
        org_y_reg    <= org_y_next;
        quad_reg     <= quad_next;
        ray_j_reg    <= ray_j_next;
        acc_x_reg    <= acc_x_next;
        acc_y_reg    <= acc_y_next;
        r1_reg       <= r1_next;
        s2_in_reg    <= s2_in_next;
        s2_idx_reg   <= s2_idx_next;
        s2_r_reg     <= s2_r_next;
        s2_last_reg  <= s2_last_next;
    end

endmodule

>>> rtl/rrds_check.sv
// ============================================================================
// rrds_check
// Port-level checks of the radial ray distance stamp, bound to the top level.
// ============================================================================
module rrds_check
    import rrds_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [KIND_W-1:0] kind,
    input logic              out_valid,
    input logic              out_stall,
    input logic [DIST_W-1:0] read_distance
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_distance))
        else $error("stalled result changed or dropped");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction taken while an item is in work");

    a_stamp_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == KIND_STAMP |=> in_stall ##1 in_stall)
        else $error("stamp finished too early");

    a_sweep_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> in_stall)
        else $error("input open before map sweep");

endmodule

bind radial_ray_distance_stamp rrds_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_distance (read_distance)
);
